// ===== hdl/mr_pkg.sv =====
// ----------------------------------------------------------------------------
// mr_pkg
// Shared types and codes for the free-rectangle placement block.
// ----------------------------------------------------------------------------
package mr_pkg;

  localparam int COORD_BITS = 12;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] item_width;
    logic [COORD_BITS-1:0] item_height;
    logic [7:0]            type_tag;
  } item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  rotated;
    logic [7:0]            tag_out;
  } result_t;

  localparam logic [1:0] STAT_PLACED  = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_OVF     = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

  localparam logic [1:0] FIT_SHORT    = 2'd0;
  localparam logic [1:0] FIT_BL       = 2'd1;
  localparam logic [1:0] FIT_AREA     = 2'd2;
  localparam logic [1:0] FIT_LONG     = 2'd3;

  localparam logic [1:0] REG_BIN_W    = 2'd0;
  localparam logic [1:0] REG_BIN_H    = 2'd1;
  localparam logic [1:0] REG_ROT      = 2'd2;
  localparam logic [1:0] REG_FIT      = 2'd3;

  localparam int CFG_BITS = COORD_BITS;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_SPLIT_RD, ST_SPLIT_PC, ST_SEL_RUN, ST_SEL_END, ST_FIN
  } state_e;

endpackage

// ===== hdl/maxrects_place.sv =====
// ----------------------------------------------------------------------------
// maxrects_place
// Rectangle placement in a bin over a table of maximal free rectangles.
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start_i while busy_o is low; the item is
// taken at that edge. Mode 1 clears the bin to one free rectangle, mode 0
// places item_width x item_height. One result per item appears on result_o
// for exactly one cycle with done_o high; it cannot be held off.
// Operation: a clear rewrites the whole-bin entry. A place scans the N free
// entries (two tries each with rotation), splits each entry into up to four
// pieces, then runs a selection sort over the P split pieces: one pass per
// distinct piece and a final pass, every pass streaming the scratch RAM
// through its single read port.
// Items are handled one at a time; busy_o stays high until the result.
// Reset: control registers take their reset values and the ST_INIT state
// writes the whole-bin entry; busy_o is high in that state. Configuration writes
// are taken at any edge with cfg_we_i and should be made while idle.
// ----------------------------------------------------------------------------
module maxrects_place import mr_pkg::*; #(
  parameter int MAX_FREE   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  item_t               item_i,
  output logic                busy_o,
  output logic                done_o,
  output result_t             result_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_FREE);
  localparam int NW = $clog2(MAX_FREE + 1);

  typedef struct packed {
    logic [CB-1:0] x, y, w, h;
  } box_t;

  function automatic logic bef(box_t a, box_t b);
    logic r;
    if (a.x != b.x) r = a.x < b.x;
    else if (a.y != b.y) r = a.y < b.y;
    else if (a.w != b.w) r = a.w > b.w;
    else r = a.h > b.h;
    return r;
  endfunction

  function automatic logic contains(box_t o, box_t i);
    return o.x <= i.x && o.y <= i.y &&
           (CB+1)'(o.x) + (CB+1)'(o.w) >= (CB+1)'(i.x) + (CB+1)'(i.w) &&
           (CB+1)'(o.y) + (CB+1)'(o.h) >= (CB+1)'(i.y) + (CB+1)'(i.h);
  endfunction

  // configuration
  logic [CB-1:0] bin_w_q, bin_h_q;
  logic          allow_rot_q;
  logic [1:0]    fit_rule_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_w_q     <= CB'(1024);
      bin_h_q     <= CB'(1024);
      allow_rot_q <= 1'b0;
      fit_rule_q  <= FIT_SHORT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIN_W: bin_w_q     <= CB'(cfg_data_i);
        REG_BIN_H: bin_h_q     <= CB'(cfg_data_i);
        REG_ROT:   allow_rot_q <= cfg_data_i[0];
        default:   fit_rule_q  <= cfg_data_i[1:0];
      endcase
    end
  end

  // memories
  logic          t_we, t_re, s_we, s_re;
  logic [AW-1:0] t_waddr, t_raddr, s_waddr, s_raddr;
  box_t          t_wdata, t_rdata, s_wdata, s_rdata;

  mr_ram #(.WIDTH(4*CB), .DEPTH(MAX_FREE)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  mr_ram #(.WIDTH(4*CB), .DEPTH(MAX_FREE)) u_scratch (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // state
  state_e        state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d, idx_q, idx_d, n_q, n_d, outn_q, outn_d;
  logic          rsel_q, rsel_d, v1_q, v1_d, r1_q, r1_d, sv_q, sv_d;
  logic          tries2_q, tries2_d, found_q, found_d;
  logic [CB-1:0] iw_q, iw_d, ih_q, ih_d;
  logic [7:0]    tag_q, tag_d;
  logic [2*CB-1:0] ba_q, ba_d, bc_q, bc_d;
  logic [CB-1:0] bb_q, bb_d;
  box_t          u_q, u_d, last_q, last_d, cand_q, cand_d;
  logic          urot_q, urot_d;
  logic [1:0]    k_q, k_d, stat_q, stat_d;
  logic          have_q, have_d, cf_q, cf_d, cont_q, cont_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;

  // scoring unit
  logic            sc_vld, sc_fit, sc_rot;
  logic [CB-1:0]   sc_x, sc_y, sc_w, sc_h, sc_b;
  logic [2*CB-1:0] sc_a, sc_c;

  mr_score #(.CB(CB)) u_score (
    .clk_i, .rst_ni, .vld_i(v1_q), .box_i(t_rdata), .rot_i(r1_q),
    .iw_i(iw_q), .ih_i(ih_q), .bin_w_i(bin_w_q), .fit_rule_i(fit_rule_q),
    .vld_o(sc_vld), .fit_o(sc_fit), .rot_o(sc_rot),
    .x_o(sc_x), .y_o(sc_y), .w_o(sc_w), .h_o(sc_h),
    .a_o(sc_a), .b_o(sc_b), .c_o(sc_c)
  );

  // split pieces of the entry held on the table read port
  logic [CB:0] uxe, uye, fxe, fye;
  logic        ov, pc_ok;
  box_t        pc_box;

  assign uxe = (CB+1)'(u_q.x) + (CB+1)'(u_q.w);
  assign uye = (CB+1)'(u_q.y) + (CB+1)'(u_q.h);
  assign fxe = (CB+1)'(t_rdata.x) + (CB+1)'(t_rdata.w);
  assign fye = (CB+1)'(t_rdata.y) + (CB+1)'(t_rdata.h);
  assign ov  = (CB+1)'(t_rdata.x) < uxe && (CB+1)'(u_q.x) < fxe &&
               (CB+1)'(t_rdata.y) < uye && (CB+1)'(u_q.y) < fye;

  always_comb begin
    pc_box = t_rdata;
    unique case (k_q)
      2'd0: begin
        pc_ok = !ov || (u_q.x > t_rdata.x);
        if (ov) pc_box.w = u_q.x - t_rdata.x;
      end
      2'd1: begin
        pc_ok    = ov && (uxe < fxe);
        pc_box.x = uxe[CB-1:0];
        pc_box.w = CB'(fxe - uxe);
      end
      2'd2: begin
        pc_ok    = ov && (u_q.y > t_rdata.y);
        pc_box.h = u_q.y - t_rdata.y;
      end
      default: begin
        pc_ok    = ov && (uye < fye);
        pc_box.y = uye[CB-1:0];
        pc_box.h = CB'(fye - uye);
      end
    endcase
  end

  logic better, keep;
  assign better = !found_q || sc_a < ba_q ||
                  (sc_a == ba_q && (sc_b < bb_q || (sc_b == bb_q && sc_c < bc_q)));
  assign keep   = have_q && !cont_q && last_q.w != '0 && last_q.h != '0;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;    idx_d   = idx_q;   n_d    = n_q;    outn_d = outn_q;
    rsel_d   = rsel_q;   v1_d    = 1'b0;    r1_d   = rsel_q; sv_d   = 1'b0;
    tries2_d = tries2_q; found_d = found_q;
    iw_d     = iw_q;     ih_d    = ih_q;    tag_d  = tag_q;
    ba_d     = ba_q;     bb_d    = bb_q;    bc_d   = bc_q;
    u_d      = u_q;      urot_d  = urot_q;
    last_d   = last_q;   cand_d  = cand_q;
    have_d   = have_q;   cf_d    = cf_q;    cont_d = cont_q;
    k_d      = k_q;      stat_d  = stat_q;
    done_d   = 1'b0;     res_d   = res_q;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_re = 1'b0; t_raddr = idx_q[AW-1:0];
    s_we = 1'b0; s_waddr = n_q[AW-1:0]; s_wdata = pc_box;
    s_re = 1'b0; s_raddr = idx_q[AW-1:0];

    unique case (state_q)
      ST_INIT: begin
        t_we    = 1'b1;
        t_wdata = '{x: '0, y: '0, w: bin_w_q, h: bin_h_q};
        cnt_d   = NW'(1);
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          tag_d = item_i.type_tag;
          if (item_i.mode) begin
            t_we    = 1'b1;
            t_wdata = '{x: '0, y: '0, w: bin_w_q, h: bin_h_q};
            cnt_d   = NW'(1);
            stat_d  = STAT_CLEARED;
            state_d = ST_FIN;
          end else begin
            iw_d     = CB'(item_i.item_width);
            ih_d     = CB'(item_i.item_height);
            tries2_d = allow_rot_q && (CB'(item_i.item_width) != CB'(item_i.item_height));
            found_d  = 1'b0;
            idx_d    = '0;
            rsel_d   = 1'b0;
            if (CB'(item_i.item_width) == '0 || CB'(item_i.item_height) == '0) begin
              stat_d  = STAT_NOFIT;
              state_d = ST_FIN;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (idx_q < cnt_q) begin
          t_re = 1'b1;
          v1_d = 1'b1;
          if (tries2_q && !rsel_q) begin
            rsel_d = 1'b1;
          end else begin
            rsel_d = 1'b0;
            idx_d  = NW'(idx_q + 1'b1);
          end
        end
        if (sc_vld && sc_fit && better) begin
          found_d = 1'b1;
          ba_d = sc_a; bb_d = sc_b; bc_d = sc_c;
          u_d  = '{x: sc_x, y: sc_y, w: sc_w, h: sc_h};
          urot_d = sc_rot;
        end
        if (!(idx_q < cnt_q) && !v1_q && !sc_vld) begin
          idx_d = '0;
          n_d   = '0;
          if (found_q) begin
            state_d = ST_SPLIT_RD;
          end else begin
            stat_d  = STAT_NOFIT;
            state_d = ST_FIN;
          end
        end
      end
      ST_SPLIT_RD: begin
        t_re    = 1'b1;
        k_d     = 2'd0;
        state_d = ST_SPLIT_PC;
      end
      ST_SPLIT_PC: begin
        k_d = k_q + 2'd1;
        if (pc_ok && n_q == NW'(MAX_FREE)) begin
          stat_d  = STAT_OVF;
          state_d = ST_FIN;
        end else begin
          if (pc_ok) begin
            s_we = 1'b1;
            n_d  = NW'(n_q + 1'b1);
          end
          if (k_q == 2'd3) begin
            idx_d = NW'(idx_q + 1'b1);
            if (NW'(idx_q + 1'b1) == cnt_q) begin
              idx_d   = '0;
              outn_d  = '0;
              have_d  = 1'b0;
              cf_d    = 1'b0;
              cont_d  = 1'b0;
              state_d = ST_SEL_RUN;
            end else begin
              state_d = ST_SPLIT_RD;
            end
          end
        end
      end
      ST_SEL_RUN: begin
        if (idx_q < n_q) begin
          s_re  = 1'b1;
          sv_d  = 1'b1;
          idx_d = NW'(idx_q + 1'b1);
        end
        if (sv_q) begin
          if ((!have_q || bef(last_q, s_rdata)) && (!cf_q || bef(s_rdata, cand_q))) begin
            cand_d = s_rdata;
            cf_d   = 1'b1;
          end
          if (have_q && contains(s_rdata, last_q) && s_rdata != last_q) begin
            cont_d = 1'b1;
          end
        end
        if (!(idx_q < n_q) && !sv_q) begin
          state_d = ST_SEL_END;
        end
      end
      ST_SEL_END: begin
        if (keep) begin
          t_we    = 1'b1;
          t_waddr = outn_q[AW-1:0];
          t_wdata = last_q;
          outn_d  = NW'(outn_q + 1'b1);
        end
        idx_d = '0;
        if (cf_q) begin
          last_d  = cand_q;
          have_d  = 1'b1;
          cf_d    = 1'b0;
          cont_d  = 1'b0;
          state_d = ST_SEL_RUN;
        end else begin
          cnt_d   = outn_d;
          stat_d  = STAT_PLACED;
          state_d = ST_FIN;
        end
      end
      default: begin
        done_d         = 1'b1;
        res_d.status   = stat_q;
        res_d.tag_out  = tag_q;
        res_d.pos_x    = (stat_q == STAT_PLACED) ? u_q.x : '0;
        res_d.pos_y    = (stat_q == STAT_PLACED) ? u_q.y : '0;
        res_d.rotated  = (stat_q == STAT_PLACED) && urot_q;
        state_d        = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= NW'(1);
      idx_q   <= '0;
      n_q     <= '0;
      outn_q  <= '0;
      rsel_q  <= 1'b0;
      v1_q    <= 1'b0;
      r1_q    <= 1'b0;
      sv_q    <= 1'b0;
      found_q <= 1'b0;
      have_q  <= 1'b0;
      cf_q    <= 1'b0;
      cont_q  <= 1'b0;
      k_q     <= 2'd0;
      stat_q  <= STAT_NOFIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      outn_q  <= outn_d;
      rsel_q  <= rsel_d;
      v1_q    <= v1_d;
      r1_q    <= r1_d;
      sv_q    <= sv_d;
      found_q <= found_d;
      have_q  <= have_d;
      cf_q    <= cf_d;
      cont_q  <= cont_d;
      k_q     <= k_d;
      stat_q  <= stat_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tries2_q <= tries2_d;
    iw_q     <= iw_d;
    ih_q     <= ih_d;
    tag_q    <= tag_d;
    ba_q     <= ba_d;
    bb_q     <= bb_d;
    bc_q     <= bc_d;
    u_q      <= u_d;
    urot_q   <= urot_d;
    last_q   <= last_d;
    cand_q   <= cand_d;
    res_q    <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hdl/mr_ram.sv =====
// ----------------------------------------------------------------------------
// mr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/mr_score.sv =====
// ----------------------------------------------------------------------------
// mr_score
// Fit test and score triple for one free rectangle and one item orientation.
// Products are registered; the triple is selected after the register.
// ----------------------------------------------------------------------------
module mr_score import mr_pkg::*; #(
  parameter int CB = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [4*CB-1:0] box_i,
  input  logic            rot_i,
  input  logic [CB-1:0]   iw_i,
  input  logic [CB-1:0]   ih_i,
  input  logic [CB-1:0]   bin_w_i,
  input  logic [1:0]      fit_rule_i,
  output logic            vld_o,
  output logic            fit_o,
  output logic            rot_o,
  output logic [CB-1:0]   x_o,
  output logic [CB-1:0]   y_o,
  output logic [CB-1:0]   w_o,
  output logic [CB-1:0]   h_o,
  output logic [2*CB-1:0] a_o,
  output logic [CB-1:0]   b_o,
  output logic [2*CB-1:0] c_o
);

  typedef struct packed {
    logic [CB-1:0] x, y, w, h;
  } box_t;

  box_t            f;
  logic [CB-1:0]   w, h, dw, dh;
  logic [CB-1:0]   dw_q, dh_q;
  logic [2*CB-1:0] ff_q, wh_q, pos_q, dd_q;
  logic [CB:0]     yh_q;
  logic [CB-1:0]   lo, hi;

  assign f  = box_t'(box_i);
  assign w  = rot_i ? ih_i : iw_i;
  assign h  = rot_i ? iw_i : ih_i;
  assign dw = f.w - w;
  assign dh = f.h - h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      fit_o <= (w <= f.w) && (h <= f.h);
      rot_o <= rot_i;
      x_o   <= f.x;
      y_o   <= f.y;
      w_o   <= w;
      h_o   <= h;
      dw_q  <= dw;
      dh_q  <= dh;
      ff_q  <= f.w * f.h;
      wh_q  <= w * h;
      pos_q <= f.y * bin_w_i + (2*CB)'(f.x);
      dd_q  <= dw * dh;
      yh_q  <= (CB+1)'(f.y) + (CB+1)'(h);
    end
  end

  assign lo = (dw_q < dh_q) ? dw_q : dh_q;
  assign hi = (dw_q < dh_q) ? dh_q : dw_q;

  always_comb begin
    unique case (fit_rule_i)
      FIT_SHORT: begin
        a_o = (2*CB)'(lo); b_o = hi; c_o = pos_q;
      end
      FIT_BL: begin
        a_o = (2*CB)'(yh_q); b_o = x_o; c_o = dd_q;
      end
      FIT_AREA: begin
        a_o = ff_q - wh_q; b_o = lo; c_o = pos_q;
      end
      default: begin
        a_o = (2*CB)'(hi); b_o = lo; c_o = pos_q;
      end
    endcase
  end

endmodule

// ===== hdl/maxrects_place_chk.sv =====
// ----------------------------------------------------------------------------
// maxrects_place_chk
// Port-level checks on the placement block, bound to its top level.
// ----------------------------------------------------------------------------
module maxrects_place_chk import mr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input item_t   item_i,
  input logic    busy_o,
  input logic    done_o,
  input result_t result_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while busy");

  a_place_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !item_i.mode) |=> busy_o)
    else $error("place item not taken");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.mode) |=> ##1 (done_o && result_o.status == STAT_CLEARED))
    else $error("clear result missing");

  a_unplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != STAT_PLACED) |->
      (result_o.pos_x == '0 && result_o.pos_y == '0 && !result_o.rotated))
    else $error("position on unplaced item");

endmodule

bind maxrects_place maxrects_place_chk u_chk (
  .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .result_o
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for maxrects_place: directed table and directed
// configuration cases, then random phases under varied bin size, rotation
// and fit rule, checked by a free-rectangle predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mr_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int CYC_LIMIT = 20000000;
  localparam int N_RAND    = 560;

  typedef struct {
    int unsigned x, y, w, h;
  } rect_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  item_t               item_i = '0;
  logic                busy_o;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  maxrects_place dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  int unsigned bin_w = 1024, bin_h = 1024;
  bit          rot_ok = 1'b0;
  logic [1:0]  fit_sel = FIT_SHORT;
  rect_t       free_tbl[TBL_DEPTH];
  int          free_cnt = 1;

  result_t exp_q[$];
  row_t    dir[$];
  int      n_err = 0, n_sent = 0;
  int      n_stat[4] = '{0, 0, 0, 0};
  int      cyc = 0;

  function automatic result_t place_item(item_t it);
    result_t r;
    rect_t u, sc[TBL_DEPTH], pc[4];
    rect_t v, f;
    bit gone[TBL_DEPTH];
    bit found;
    longint unsigned a, b, c, s1, s2, s3, dw, dh, lo, hi, pos;
    int unsigned iw, ih, w, h, tries, urot;
    int n, m, k, j;
    r = '0;
    r.tag_out = it.type_tag;
    if (it.mode) begin
      free_tbl[0] = '{0, 0, bin_w, bin_h};
      free_cnt = 1;
      r.status = STAT_CLEARED;
      return r;
    end
    r.status = STAT_NOFIT;
    iw = it.item_width;
    ih = it.item_height;
    if (iw == 0 || ih == 0) return r;
    tries = (rot_ok && iw != ih) ? 2 : 1;
    found = 0; s1 = 0; s2 = 0; s3 = 0; urot = 0; u = '{0, 0, 0, 0};
    for (int i = 0; i < free_cnt; i++) begin
      f = free_tbl[i];
      for (int t = 0; t < tries; t++) begin
        w = t ? ih : iw;
        h = t ? iw : ih;
        if (w > f.w || h > f.h) continue;
        dw = f.w - w; dh = f.h - h;
        lo = dw < dh ? dw : dh;
        hi = dw < dh ? dh : dw;
        pos = longint'(f.y) * bin_w + f.x;
        case (fit_sel)
          FIT_SHORT: begin a = lo; b = hi; c = pos; end
          FIT_BL:    begin a = f.y + h; b = f.x; c = dw * dh; end
          FIT_AREA:  begin a = longint'(f.w) * f.h - longint'(w) * h; b = lo; c = pos; end
          default:   begin a = hi; b = lo; c = pos; end
        endcase
        if (!found || a < s1 || (a == s1 && (b < s2 || (b == s2 && c < s3)))) begin
          found = 1; s1 = a; s2 = b; s3 = c;
          u = '{f.x, f.y, w, h}; urot = t;
        end
      end
    end
    if (!found) return r;
    n = 0;
    for (int i = 0; i < free_cnt; i++) begin
      f = free_tbl[i];
      k = 0;
      if (!(f.x < u.x + u.w && u.x < f.x + f.w && f.y < u.y + u.h && u.y < f.y + f.h)) begin
        pc[k++] = f;
      end else begin
        if (u.x > f.x) pc[k++] = '{f.x, f.y, u.x - f.x, f.h};
        if (u.x + u.w < f.x + f.w) pc[k++] = '{u.x + u.w, f.y, f.x + f.w - u.x - u.w, f.h};
        if (u.y > f.y) pc[k++] = '{f.x, f.y, f.w, u.y - f.y};
        if (u.y + u.h < f.y + f.h) pc[k++] = '{f.x, u.y + u.h, f.w, f.y + f.h - u.y - u.h};
      end
      for (int q = 0; q < k; q++) begin
        if (n >= TBL_DEPTH) begin
          r.status = STAT_OVF;
          return r;
        end
        sc[n++] = pc[q];
      end
    end
    for (int i = 1; i < n; i++) begin
      v = sc[i];
      j = i;
      while (j > 0 && (v.x != sc[j-1].x ? v.x < sc[j-1].x :
                       v.y != sc[j-1].y ? v.y < sc[j-1].y :
                       v.w != sc[j-1].w ? v.w > sc[j-1].w : v.h > sc[j-1].h)) begin
        sc[j] = sc[j-1];
        j--;
      end
      sc[j] = v;
    end
    m = 0;
    for (int i = 0; i < n; i++) begin
      if (m > 0 && sc[m-1].x == sc[i].x && sc[m-1].y == sc[i].y &&
          sc[m-1].w == sc[i].w && sc[m-1].h == sc[i].h) continue;
      sc[m++] = sc[i];
    end
    for (int i = 0; i < m; i++) begin
      gone[i] = 0;
      for (int q = 0; q < m && !gone[i]; q++)
        if (i != q && sc[q].x <= sc[i].x && sc[q].y <= sc[i].y &&
            sc[q].x + sc[q].w >= sc[i].x + sc[i].w &&
            sc[q].y + sc[q].h >= sc[i].y + sc[i].h) gone[i] = 1;
    end
    n = 0;
    for (int i = 0; i < m; i++)
      if (!gone[i] && sc[i].w > 0 && sc[i].h > 0) free_tbl[n++] = sc[i];
    free_cnt = n;
    r.status  = STAT_PLACED;
    r.pos_x   = 12'(u.x);
    r.pos_y   = 12'(u.y);
    r.rotated = urot[0];
    return r;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t res);
    result_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    item_i  <= it;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    p = place_item(it);
    exp_q.insert(exp_q.size(), typed ? res : p);
    n_sent++;
  endtask

  task automatic add_row(item_t it, bit typed, result_t res);
    row_t rw;
    rw.it    = it;
    rw.typed = typed;
    rw.res   = res;
    dir.insert(dir.size(), rw);
  endtask

  task automatic wait_idle();
    while (exp_q.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BIN_W: bin_w = val & 12'hFFF;
      REG_BIN_H: bin_h = val & 12'hFFF;
      REG_ROT:   rot_ok = val[0];
      default:   fit_sel = val[1:0];
    endcase
  endtask

  function automatic item_t mk_item(bit md, int unsigned w, int unsigned h, int unsigned tg);
    item_t it;
    it.mode = md;
    it.item_width = 12'(w);
    it.item_height = 12'(h);
    it.type_tag = 8'(tg);
    return it;
  endfunction

  function automatic result_t mk_res(logic [1:0] st, int unsigned x, int unsigned y,
                                     bit rt, int unsigned tg);
    result_t r;
    r.status = st;
    r.pos_x = 12'(x);
    r.pos_y = 12'(y);
    r.rotated = rt;
    r.tag_out = 8'(tg);
    return r;
  endfunction

  function automatic int unsigned rand_dim(int unsigned lim);
    int unsigned top;
    top = (lim < 2) ? 2 : lim;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 4095);
      1:       return 4095;
      2:       return 0;
      3:       return top;
      default: return $urandom_range(1, (top / 4 < 1) ? 1 : top / 4);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (exp_q.size() == 0) begin
        $error("result with nothing expected: %p", result_o);
        n_err++;
      end else begin
        result_t e;
        e = exp_q.pop_front();
        n_stat[result_o.status]++;
        if (result_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result_o.status); n_err++;
        end
        if (result_o.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, result_o.pos_x); n_err++;
        end
        if (result_o.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, result_o.pos_y); n_err++;
        end
        if (result_o.rotated !== e.rotated) begin
          $error("rotated exp %0d got %0d", e.rotated, result_o.rotated); n_err++;
        end
        if (result_o.tag_out !== e.tag_out) begin
          $error("tag_out exp %0d got %0d", e.tag_out, result_o.tag_out); n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    result_t none;
    int unsigned bw, bh;
    none = '0;
    add_row(mk_item(0, 4095, 4095, 8'hFF), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'hFF));
    add_row(mk_item(0, 0, 5, 8'h01), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'h01));
    add_row(mk_item(0, 5, 0, 8'h02), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'h02));
    add_row(mk_item(0, 1024, 1024, 8'h00), 1, mk_res(STAT_PLACED, 0, 0, 0, 8'h00));
    add_row(mk_item(0, 1, 1, 8'h55), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'h55));
    add_row(mk_item(1, 4095, 4095, 8'hA5), 1, mk_res(STAT_CLEARED, 0, 0, 0, 8'hA5));
    add_row(mk_item(0, 1, 1, 8'h10), 1, mk_res(STAT_PLACED, 0, 0, 0, 8'h10));
    add_row(mk_item(0, 1023, 1, 8'h11), 0, none);
    add_row(mk_item(0, 1, 1023, 8'h12), 0, none);
    add_row(mk_item(0, 300, 200, 8'h13), 0, none);
    add_row(mk_item(0, 200, 300, 8'h14), 0, none);
    add_row(mk_item(0, 512, 512, 8'h15), 0, none);
    add_row(mk_item(0, 2048, 10, 8'h16), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'h16));
    add_row(mk_item(1, 0, 0, 8'h00), 1, mk_res(STAT_CLEARED, 0, 0, 0, 8'h00));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir[i]) send_item(dir[i].it, dir[i].typed, dir[i].res);

    // largest bin, rotation on, the BL, area and long-side fit rules
    write_reg(REG_BIN_W, 4095);
    write_reg(REG_BIN_H, 4095);
    write_reg(REG_ROT, 1);
    write_reg(REG_FIT, FIT_BL);
    send_item(mk_item(1, 1, 1, 8'h20), 1, mk_res(STAT_CLEARED, 0, 0, 0, 8'h20));
    send_item(mk_item(0, 100, 40, 8'h21), 0, none);
    send_item(mk_item(0, 40, 4095, 8'h22), 0, none);
    send_item(mk_item(0, 4095, 4095, 8'h23), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'h23));
    write_reg(REG_FIT, FIT_AREA);
    send_item(mk_item(0, 4095, 30, 8'h24), 0, none);
    write_reg(REG_FIT, FIT_LONG);
    send_item(mk_item(0, 7, 9, 8'h25), 0, none);
    // empty bin: nothing fits after clear
    write_reg(REG_BIN_W, 0);
    send_item(mk_item(1, 0, 0, 8'h26), 1, mk_res(STAT_CLEARED, 0, 0, 0, 8'h26));
    send_item(mk_item(0, 1, 1, 8'h27), 1, mk_res(STAT_NOFIT, 0, 0, 0, 8'h27));

    while (n_sent < N_RAND) begin
      case ($urandom_range(0, 5))
        0:       bw = 4095;
        1:       bw = $urandom_range(1, 16);
        default: bw = $urandom_range(1, 4095);
      endcase
      case ($urandom_range(0, 5))
        0:       bh = 4095;
        1:       bh = $urandom_range(1, 16);
        default: bh = $urandom_range(1, 4095);
      endcase
      if ($urandom_range(0, 19) == 0) bw = 0;
      write_reg(REG_BIN_W, bw);
      write_reg(REG_BIN_H, bh);
      write_reg(REG_ROT, $urandom_range(0, 1));
      write_reg(REG_FIT, $urandom_range(0, 3));
      send_item(mk_item(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 255)), 0, none);
      repeat ($urandom_range(20, 45)) begin
        if ($urandom_range(0, 29) == 0)
          send_item(mk_item(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 255)), 0, none);
        else
          send_item(mk_item(0, rand_dim(bin_w), rand_dim(bin_h),
                            $urandom_range(0, 255)), 0, none);
      end
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("items: %0d; placed %0d, no fit %0d, overflow %0d, cleared %0d",
             n_sent, n_stat[0], n_stat[1], n_stat[2], n_stat[3]);
    $display("covered all fit rules, rotation on/off, bin sizes from 0 to 4095");
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
